### design/arpc_pkg.sv
// Shared types and constants of the ARP cache table.
// Used by arpc_engine and arp_cache_table_unit; depends on nothing else.
package arpc_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int COUNT_FW    = 7;   // width of the entry_count result field

  localparam logic [15:0] MAX_AGE_RESET = 16'd120;
  localparam logic [15:0] AGE_LIMIT     = 16'hFFFF;

  // Configuration register indexes.
  localparam logic [1:0] CFG_OWN_HW_ADDR    = 2'd0;
  localparam logic [1:0] CFG_OWN_PROTO_ADDR = 2'd1;
  localparam logic [1:0] CFG_MAX_AGE        = 2'd2;

  typedef enum logic [2:0] {
    OP_LOOKUP  = 3'd0,
    OP_LEARN   = 3'd1,
    OP_REQUEST = 3'd2,
    OP_TICK    = 3'd3,
    OP_REMOVE  = 3'd4,
    OP_CLEAR   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_FULL      = 2'd1,
    ERR_BAD_INDEX = 2'd2,
    ERR_OWN_ADDR  = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIND,
    ST_SWEEP,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    SWEEP_TICK,
    SWEEP_REMOVE,
    SWEEP_LEARN
  } sweep_t;

  typedef struct packed {
    logic [31:0] proto_addr;
    logic [47:0] hw_addr;
    logic        resolved;
    logic [15:0] age;
  } entry_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] target_ip;
    logic [47:0] sender_mac;
    logic [5:0]  entry_index;
  } item_t;

  typedef struct packed {
    logic [47:0] own_hw_addr;
    logic [31:0] own_proto_addr;
    logic [15:0] max_age;
  } cfg_t;

  typedef struct packed {
    logic                hit;
    logic [47:0]         hw_addr;
    logic                resolved;
    err_t                error_code;
    logic [COUNT_FW-1:0] entry_count;
  } result_t;

endpackage

### design/arpc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/arpc_engine.sv
// Operation sequencer of the ARP cache: scans and rewrites the entry memory.
// Depends on arpc_pkg and arpc_ram.
module arpc_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  arpc_pkg::item_t   in_item,
  input  arpc_pkg::cfg_t    cfg,
  output logic              res_valid,
  input  logic              res_ready,
  output arpc_pkg::result_t res
);
  import arpc_pkg::*;

  state_t            state_r, state_nxt;
  sweep_t            mode_r, mode_nxt;
  op_t               op_r, op_nxt;
  logic [31:0]       ip_r, ip_nxt;
  logic [47:0]       mac_r, mac_nxt;
  logic [5:0]        idx_r, idx_nxt;
  logic [47:0]       old_mac_r, old_mac_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [CNT_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0]  dat_idx_r, dat_idx_nxt;
  logic              rvalid_r, rvalid_nxt;
  result_t           res_r, res_nxt;

  logic              rd_en;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;
  entry_t            rd_data;

  logic              issue_ok;
  logic              table_full;
  logic              match;
  logic [15:0]       aged;
  entry_t            ent_mod;
  logic              keep;

  arpc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_ptr_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign issue_ok   = rd_ptr_r < used_r;
  assign table_full = used_r == CNT_W'(TABLE_DEPTH);
  assign match      = rvalid_r && (rd_data.proto_addr == ip_r);
  assign aged       = (rd_data.age == AGE_LIMIT) ? rd_data.age : rd_data.age + 16'd1;

  // Entry as it leaves the sweep, and whether it stays in the table.
  always_comb begin
    ent_mod = rd_data;
    keep    = 1'b1;
    case (mode_r)
      SWEEP_TICK: begin
        ent_mod.age = aged;
        keep        = aged <= cfg.max_age;
      end
      SWEEP_REMOVE: begin
        keep = dat_idx_r != CNT_W'(idx_r);
      end
      SWEEP_LEARN: begin
        if (rd_data.hw_addr == old_mac_r) begin
          ent_mod.hw_addr  = mac_r;
          ent_mod.resolved = 1'b1;
        end
      end
      default: begin
        keep = 1'b1;
      end
    endcase
  end

  // Reads run ahead of writes: a write lands at or below the entry whose data
  // has just returned, while the next read is already one further on, so the
  // same entry is never read and written in overlapping cycles.
  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    op_nxt      = op_r;
    ip_nxt      = ip_r;
    mac_nxt     = mac_r;
    idx_nxt     = idx_r;
    old_mac_nxt = old_mac_r;
    used_nxt    = used_r;
    rd_ptr_nxt  = rd_ptr_r;
    wr_ptr_nxt  = wr_ptr_r;
    res_nxt     = res_r;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = used_r[IDX_W-1:0];
    wr_data     = ent_mod;
    in_ready    = 1'b0;
    res_valid   = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt     = in_item.op;
          ip_nxt     = in_item.target_ip;
          mac_nxt    = in_item.sender_mac;
          idx_nxt    = in_item.entry_index;
          rd_ptr_nxt = '0;
          wr_ptr_nxt = '0;
          res_nxt    = '0;
          res_nxt.entry_count = COUNT_FW'(used_r);
          case (in_item.op)
            OP_LOOKUP, OP_LEARN: begin
              state_nxt = ST_FIND;
            end
            OP_REQUEST: begin
              state_nxt = ST_DONE;
              if (in_item.target_ip == cfg.own_proto_addr) begin
                res_nxt.error_code = ERR_OWN_ADDR;
              end else if (table_full) begin
                res_nxt.error_code = ERR_FULL;
              end else begin
                wr_en               = 1'b1;
                wr_data             = '0;
                wr_data.proto_addr  = in_item.target_ip;
                used_nxt            = CNT_W'(used_r + 1'b1);
                res_nxt.entry_count = COUNT_FW'(used_nxt);
              end
            end
            OP_TICK: begin
              mode_nxt  = SWEEP_TICK;
              state_nxt = ST_SWEEP;
            end
            OP_REMOVE: begin
              if (32'(in_item.entry_index) < 32'(used_r)) begin
                mode_nxt  = SWEEP_REMOVE;
                state_nxt = ST_SWEEP;
              end else begin
                res_nxt.error_code = ERR_BAD_INDEX;
                state_nxt          = ST_DONE;
              end
            end
            OP_CLEAR: begin
              used_nxt            = '0;
              res_nxt.entry_count = '0;
              state_nxt           = ST_DONE;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_FIND: begin
        if (match) begin
          if (op_r == OP_LOOKUP) begin
            res_nxt.hit      = 1'b1;
            res_nxt.hw_addr  = rd_data.hw_addr;
            res_nxt.resolved = rd_data.resolved;
            state_nxt        = ST_DONE;
          end else begin
            old_mac_nxt = rd_data.hw_addr;
            mode_nxt    = SWEEP_LEARN;
            rd_ptr_nxt  = '0;
            wr_ptr_nxt  = '0;
            state_nxt   = ST_SWEEP;
          end
        end else if (issue_ok) begin
          rd_en      = 1'b1;
          rd_ptr_nxt = CNT_W'(rd_ptr_r + 1'b1);
        end else if (!rvalid_r) begin
          // Whole table scanned without a match.
          state_nxt = ST_DONE;
          if (op_r == OP_LEARN) begin
            if (table_full) begin
              res_nxt.error_code = ERR_FULL;
            end else begin
              wr_en               = 1'b1;
              wr_data.proto_addr  = ip_r;
              wr_data.hw_addr     = mac_r;
              wr_data.resolved    = mac_r != cfg.own_hw_addr;
              wr_data.age         = '0;
              used_nxt            = CNT_W'(used_r + 1'b1);
              res_nxt.entry_count = COUNT_FW'(used_nxt);
            end
          end
        end
      end

      ST_SWEEP: begin
        if (issue_ok) begin
          rd_en      = 1'b1;
          rd_ptr_nxt = CNT_W'(rd_ptr_r + 1'b1);
        end
        if (rvalid_r) begin
          if (keep) begin
            wr_en      = 1'b1;
            wr_addr    = wr_ptr_r[IDX_W-1:0];
            wr_ptr_nxt = CNT_W'(wr_ptr_r + 1'b1);
          end
        end else if (!issue_ok) begin
          used_nxt            = wr_ptr_r;
          res_nxt.entry_count = COUNT_FW'(wr_ptr_r);
          if (mode_r == SWEEP_LEARN) begin
            res_nxt.hit      = 1'b1;
            res_nxt.hw_addr  = mac_r;
            res_nxt.resolved = 1'b1;
          end
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign rvalid_nxt  = rd_en;
  assign dat_idx_nxt = rd_en ? rd_ptr_r : dat_idx_r;
  assign res         = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      used_r   <= '0;
      rvalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      used_r   <= used_nxt;
      rvalid_r <= rvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    op_r      <= op_nxt;
    ip_r      <= ip_nxt;
    mac_r     <= mac_nxt;
    idx_r     <= idx_nxt;
    old_mac_r <= old_mac_nxt;
    rd_ptr_r  <= rd_ptr_nxt;
    wr_ptr_r  <= wr_ptr_nxt;
    dat_idx_r <= dat_idx_nxt;
    res_r     <= res_nxt;
  end

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_sweep_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> (wr_ptr_r <= rd_ptr_r))
    else $error("sweep write pointer overtook read pointer");

  a_find_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIND && match) |-> !wr_en)
    else $error("memory written while a match is being taken");

  a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |=> !rvalid_r)
    else $error("read data returned for an item not yet started");

endmodule

### design/arp_cache_table_unit.sv
// The ARP cache table returns one result item for each operation item it
// accepts. Lookup and learn scan the table one entry per cycle until the first
// match; a learn hit then sweeps the whole table once more. Tick and remove
// sweep the table once, compacting it in place. Request, clear, a remove with
// a bad index and an unknown op skip the scan. Each item also hands its result
// to the output register. The single read port of the entry memory, which
// serves one entry a cycle, sets the pace of every scan and sweep. The next
// item is taken while a finished result still waits at the output. No clearing
// pass is needed after reset.
// Holds the top level: configuration registers and the output register.
// Depends on arpc_pkg and arpc_engine.
module arp_cache_table_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // op[2:0], target_ip[34:3], sender_mac[82:35], entry_index[88:83], zero fill
  input  logic [95:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // hit[0], hw_addr[48:1], resolved[49], error_code[51:50], entry_count[58:52]
  output logic [63:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  import arpc_pkg::*;

  cfg_t        cfg_r, cfg_nxt;
  item_t       item;
  logic        res_valid;
  logic        res_ready;
  result_t     res;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_data_r, out_data_nxt;

  assign item.op          = op_t'(in_tdata[2:0]);
  assign item.target_ip   = in_tdata[34:3];
  assign item.sender_mac  = in_tdata[82:35];
  assign item.entry_index = in_tdata[88:83];

  arpc_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (item),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_OWN_HW_ADDR:    cfg_nxt.own_hw_addr    = cfg_data;
        CFG_OWN_PROTO_ADDR: cfg_nxt.own_proto_addr = cfg_data[31:0];
        CFG_MAX_AGE:        cfg_nxt.max_age        = cfg_data[15:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  // The output register takes a new result whenever it is empty or draining.
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_data_nxt = {5'b0, res.entry_count, res.error_code, res.resolved,
                        res.hw_addr, res.hit};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_hw_addr    <= '0;
      cfg_r.own_proto_addr <= '0;
      cfg_r.max_age        <= MAX_AGE_RESET;
      out_valid_r          <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### bench/tb_arp_cache_table_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for arp_cache_table_unit: a shadow copy of the table
// predicts every result item, which is compared field by field on arrival.
// Depends on arpc_pkg and the block itself.
module tb_arp_cache_table_unit;
  import arpc_pkg::*;

  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          DRAIN_WAIT  = 2 * TABLE_DEPTH + 20;
  localparam logic [2:0]  OP_SPARE_6  = 3'd6;
  localparam logic [2:0]  OP_SPARE_7  = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [5:0]  idx;
  } arp_op_s;

  typedef struct {
    logic        hit;
    logic [47:0] hw;
    logic        res;
    logic [1:0]  err;
    logic [6:0]  cnt;
  } reply_s;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;

  arp_cache_table_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the table and of the registers.
  logic [31:0] shadow_ip  [TABLE_DEPTH];
  logic [47:0] shadow_mac [TABLE_DEPTH];
  logic        shadow_res [TABLE_DEPTH];
  logic [15:0] shadow_age [TABLE_DEPTH];
  int          shadow_used = 0;
  logic [47:0] own_mac = '0;
  logic [31:0] own_ip  = '0;
  logic [15:0] age_max = MAX_AGE_RESET;

  arp_op_s pending_ops[$];
  reply_s  expected_replies[$];
  arp_op_s cur_op;
  int      queued_cnt = 0;
  int      sent_cnt = 0;
  int      checked_cnt = 0;
  int      fail_cnt = 0;
  int      hit_cnt = 0, full_cnt = 0, own_cnt = 0, bad_idx_cnt = 0;
  int      setting_cnt = 0;
  int      cycle_cnt = 0;
  int      burst_left = 1;
  int      gap_left = 0;
  int      stall_left = 0;
  int      stall_mode = 0;

  logic [31:0] ip_pool  [16];
  logic [47:0] mac_pool [8];

  function automatic void drop_entry(int pos);
    for (int k = pos; k + 1 < shadow_used; k++) begin
      shadow_ip[k]  = shadow_ip[k + 1];
      shadow_mac[k] = shadow_mac[k + 1];
      shadow_res[k] = shadow_res[k + 1];
      shadow_age[k] = shadow_age[k + 1];
    end
    shadow_used--;
  endfunction

  function automatic logic append_entry(logic [31:0] ip, logic [47:0] mac, logic res);
    if (shadow_used >= TABLE_DEPTH) return 1'b0;
    shadow_ip[shadow_used]  = ip;
    shadow_mac[shadow_used] = mac;
    shadow_res[shadow_used] = res;
    shadow_age[shadow_used] = '0;
    shadow_used++;
    return 1'b1;
  endfunction

  // Applies one operation to the shadow table and returns the reply it causes.
  function automatic reply_s predict_reply(arp_op_s o);
    reply_s      r;
    int          pos;
    int          k;
    logic [47:0] old_mac;
    r = '{hit: 1'b0, hw: '0, res: 1'b0, err: ERR_OK, cnt: '0};
    pos = -1;
    if (o.op == OP_LOOKUP || o.op == OP_LEARN) begin
      for (k = 0; k < shadow_used; k++)
        if (pos < 0 && shadow_ip[k] == o.ip) pos = k;
    end
    case (o.op)
      OP_LOOKUP: begin
        if (pos >= 0) begin
          r.hit = 1'b1;
          r.hw  = shadow_mac[pos];
          r.res = shadow_res[pos];
        end
      end
      OP_LEARN: begin
        if (pos >= 0) begin
          // Every entry sharing the matched entry's old MAC moves to the new one.
          old_mac = shadow_mac[pos];
          for (k = 0; k < shadow_used; k++)
            if (shadow_mac[k] == old_mac) begin
              shadow_mac[k] = o.mac;
              shadow_res[k] = 1'b1;
            end
          r.hit = 1'b1;
          r.hw  = o.mac;
          r.res = 1'b1;
        end else if (!append_entry(o.ip, o.mac, o.mac != own_mac)) begin
          r.err = ERR_FULL;
        end
      end
      OP_REQUEST: begin
        if (o.ip == own_ip) r.err = ERR_OWN_ADDR;
        else if (!append_entry(o.ip, '0, 1'b0)) r.err = ERR_FULL;
      end
      OP_TICK: begin
        k = 0;
        while (k < shadow_used) begin
          if (shadow_age[k] != AGE_LIMIT) shadow_age[k]++;
          if (shadow_age[k] > age_max) drop_entry(k);
          else k++;
        end
      end
      OP_REMOVE: begin
        if (int'(o.idx) < shadow_used) drop_entry(int'(o.idx));
        else r.err = ERR_BAD_INDEX;
      end
      OP_CLEAR: shadow_used = 0;
      default: ;
    endcase
    r.cnt = shadow_used[6:0];
    return r;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    logic launch;
    launch = 1'b0;
    if (in_tvalid && in_tready) begin
      expected_replies.insert(expected_replies.size(), predict_reply(cur_op));
      sent_cnt++;
    end
    if (!in_tvalid || in_tready) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_ops.size() > 0) begin
        cur_op = pending_ops.pop_front();
        in_tdata <= {7'd0, cur_op.idx, cur_op.mac, cur_op.ip, cur_op.op};
        launch = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
        end
      end
      in_tvalid <= launch;
    end
  end

  // Receiver: checks each result item and drives out_tready from one of four
  // ready patterns, picked anew at random.
  always @(posedge clk) begin
    reply_s got;
    reply_s want;
    logic   ready_next;
    if (rst_n && out_tvalid && out_tready) begin
      got.hit = out_tdata[0];
      got.hw  = out_tdata[48:1];
      got.res = out_tdata[49];
      got.err = out_tdata[51:50];
      got.cnt = out_tdata[58:52];
      if (expected_replies.size() == 0) begin
        $error("result item with nothing expected: %h", out_tdata);
        fail_cnt++;
      end else begin
        want = expected_replies.pop_front();
        checked_cnt++;
        if (got.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, got.hit);
          fail_cnt++;
        end
        if (got.hw !== want.hw) begin
          $error("hw_addr: expected %h, got %h", want.hw, got.hw);
          fail_cnt++;
        end
        if (got.res !== want.res) begin
          $error("resolved: expected %0d, got %0d", want.res, got.res);
          fail_cnt++;
        end
        if (got.err !== want.err) begin
          $error("error_code: expected %0d, got %0d", want.err, got.err);
          fail_cnt++;
        end
        if (got.cnt !== want.cnt) begin
          $error("entry_count: expected %0d, got %0d", want.cnt, got.cnt);
          fail_cnt++;
        end
        if (want.hit) hit_cnt++;
        case (want.err)
          ERR_FULL:      full_cnt++;
          ERR_OWN_ADDR:  own_cnt++;
          ERR_BAD_INDEX: bad_idx_cnt++;
          default: ;
        endcase
      end
    end
    if (stall_left > 0) begin
      stall_left--;
    end else begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(50, 400);
    end
    case (stall_mode)
      0:       ready_next = 1'b1;
      1:       ready_next = ($urandom_range(0, 3) != 0);
      2:       ready_next = ($urandom_range(0, 9) < 3);
      default: ready_next = (cycle_cnt % 4 == 0);
    endcase
    out_tready <= ready_next;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void push_op(logic [2:0] op, logic [31:0] ip, logic [47:0] mac,
                                  logic [5:0] idx);
    arp_op_s o;
    o = '{op: op, ip: ip, mac: mac, idx: idx};
    pending_ops.insert(pending_ops.size(), o);
    queued_cnt++;
  endfunction

  function automatic logic [47:0] rand_mac();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[47:0];
  endfunction

  // Called just after a rising edge; returns once cfg_r holds the new value.
  task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_OWN_HW_ADDR:    own_mac = val;
      CFG_OWN_PROTO_ADDR: own_ip  = val[31:0];
      CFG_MAX_AGE:        age_max = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Waits until every queued item has been sent and answered.
  task automatic wait_idle();
    do @(posedge clk); while (sent_cnt != queued_cnt || expected_replies.size() != 0);
  endtask

  // Mostly addresses from small pools, so that hits, shared MACs and a full
  // table are common; the rest are fully random values and our own addresses.
  task automatic run_phase(input int n_items, input int tick_w);
    int          r;
    int          sel;
    logic [2:0]  op;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [5:0]  idx;
    setting_cnt++;
    for (int n = 0; n < n_items; n++) begin
      r = $urandom_range(0, 99);
      if (r < 26)               op = OP_LOOKUP;
      else if (r < 50)          op = OP_LEARN;
      else if (r < 70)          op = OP_REQUEST;
      else if (r < 70 + tick_w) op = OP_TICK;
      else if (r < 96)          op = OP_REMOVE;
      else if (r < 98)          op = OP_CLEAR;
      else                      op = ($urandom_range(0, 1) != 0) ? OP_SPARE_6 : OP_SPARE_7;
      sel = $urandom_range(0, 19);
      if (sel < 17)      ip = ip_pool[$urandom_range(0, 15)];
      else if (sel < 19) ip = own_ip;
      else               ip = $urandom();
      sel = $urandom_range(0, 9);
      if (sel < 8)       mac = mac_pool[$urandom_range(0, 7)];
      else if (sel < 9)  mac = own_mac;
      else               mac = rand_mac();
      idx = ($urandom_range(0, 1) != 0) ? 6'($urandom_range(0, 3)) : 6'($urandom_range(0, 63));
      push_op(op, ip, mac, idx);
    end
    wait_idle();
  endtask

  initial begin
    for (int k = 0; k < 16; k++) ip_pool[k] = $urandom();
    for (int k = 0; k < 8; k++) mac_pool[k] = rand_mac();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part runs with the reset value of max_age.
    write_reg(CFG_OWN_HW_ADDR, 48'h0200_5E10_2030);
    write_reg(CFG_OWN_PROTO_ADDR, {16'd0, 32'hC0A8_0001});
    setting_cnt++;
    push_op(OP_LOOKUP,  32'h0000_0000, '0, '0);
    push_op(OP_LEARN,   32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, '0);
    push_op(OP_LEARN,   32'h0000_0000, own_mac, 6'h3F);
    push_op(OP_REQUEST, 32'h0A00_0001, '0, '0);
    push_op(OP_REQUEST, 32'h0A00_0002, 48'h1, 6'd1);
    push_op(OP_REQUEST, own_ip, rand_mac(), '0);
    push_op(OP_LOOKUP,  32'hFFFF_FFFF, '0, '0);
    push_op(OP_LOOKUP,  32'h0000_0000, '0, '0);
    push_op(OP_LOOKUP,  32'h0A00_0001, '0, '0);
    // Both zero-MAC request entries take the learned MAC.
    push_op(OP_LEARN,   32'h0A00_0001, 48'h0000_1234_5678, '0);
    push_op(OP_LOOKUP,  32'h0A00_0002, '0, '0);
    push_op(OP_LEARN,   32'h0000_0000, 48'hA5A5_5A5A_A5A5, '0);
    push_op(OP_REMOVE,  '0, '0, 6'd63);
    push_op(OP_REMOVE,  '0, '0, 6'd0);
    push_op(OP_TICK,    '0, '0, '0);
    push_op(OP_SPARE_6, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 6'h3F);
    push_op(OP_SPARE_7, '0, '0, '0);
    push_op(OP_LOOKUP,  32'h0A00_0002, '0, '0);
    push_op(OP_CLEAR,   '0, '0, '0);
    push_op(OP_REMOVE,  '0, '0, 6'd0);
    push_op(OP_LOOKUP,  32'hFFFF_FFFF, '0, '0);
    wait_idle();

    // Few ticks and a long lifetime: the table fills up.
    write_reg(CFG_OWN_HW_ADDR, mac_pool[0]);
    write_reg(CFG_OWN_PROTO_ADDR, {16'd0, ip_pool[0]});
    run_phase(400, 4);

    write_reg(CFG_MAX_AGE, 48'd3);
    run_phase(400, 15);

    write_reg(CFG_OWN_HW_ADDR, 48'hFFFF_FFFF_FFFF);
    write_reg(CFG_OWN_PROTO_ADDR, {16'd0, 32'hFFFF_FFFF});
    write_reg(CFG_MAX_AGE, 48'd65535);
    run_phase(350, 6);

    write_reg(CFG_OWN_HW_ADDR, 48'd0);
    write_reg(CFG_OWN_PROTO_ADDR, 48'd0);
    write_reg(CFG_MAX_AGE, 48'd1);
    run_phase(300, 12);

    // With a zero lifetime every tick empties the table.
    write_reg(CFG_MAX_AGE, 48'd0);
    run_phase(100, 10);

    write_reg(CFG_OWN_HW_ADDR, mac_pool[3]);
    write_reg(CFG_OWN_PROTO_ADDR, {16'd0, ip_pool[5]});
    write_reg(CFG_MAX_AGE, 48'($urandom_range(8, 40)));
    run_phase(400, 10);

    repeat (DRAIN_WAIT) @(posedge clk);
    $display("%0d result items checked over %0d register settings: %0d hits,",
             checked_cnt, setting_cnt, hit_cnt);
    $display("%0d table-full, %0d own-address and %0d bad-index replies.",
             full_cnt, own_cnt, bad_idx_cnt);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
